// ----- rtl/mcd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, constants and the symbol group lookup for the Morse decoder.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam logic [7:0] MCD_DASH        = 8'd45;
    localparam logic [7:0] MCD_DOT         = 8'd46;
    localparam int         MCD_SYM_W       = 7;
    localparam int         MCD_CNT_W       = 3;
    localparam logic [2:0] MCD_MAX_SYMBOLS = 3'd7;
    localparam int         MCD_CHAR_W      = 7;
    localparam int         MCD_QUEUE_DEPTH = 2;

    // Closed group: symbol count and symbols, newest in bit 0, dash = 1.
    typedef struct packed {
        logic [MCD_CNT_W-1:0] count;
        logic [MCD_SYM_W-1:0] bits;
    } t_group;

    localparam int MCD_GROUP_W = $bits(t_group);

    typedef struct packed {
        logic                  hit;
        logic [MCD_CHAR_W-1:0] character;
    } t_decode;

    function automatic t_decode mcd_hit(input logic [7:0] c);
        t_decode d;
        d.hit       = 1'b1;
        d.character = c[MCD_CHAR_W-1:0];
        return d;
    endfunction

    function automatic t_decode mcd_decode(input t_group g);
        t_decode d;
        d = '0;
        unique case ({g.count, g.bits})
            {3'd1, 7'd0}:  d = mcd_hit("e");
            {3'd1, 7'd1}:  d = mcd_hit("t");
            {3'd2, 7'd0}:  d = mcd_hit("i");
            {3'd2, 7'd1}:  d = mcd_hit("a");
            {3'd2, 7'd2}:  d = mcd_hit("n");
            {3'd2, 7'd3}:  d = mcd_hit("m");
            {3'd3, 7'd0}:  d = mcd_hit("s");
            {3'd3, 7'd1}:  d = mcd_hit("u");
            {3'd3, 7'd2}:  d = mcd_hit("r");
            {3'd3, 7'd3}:  d = mcd_hit("w");
            {3'd3, 7'd4}:  d = mcd_hit("d");
            {3'd3, 7'd5}:  d = mcd_hit("k");
            {3'd3, 7'd6}:  d = mcd_hit("g");
            {3'd3, 7'd7}:  d = mcd_hit("o");
            {3'd4, 7'd0}:  d = mcd_hit("h");
            {3'd4, 7'd1}:  d = mcd_hit("v");
            {3'd4, 7'd2}:  d = mcd_hit("f");
            {3'd4, 7'd4}:  d = mcd_hit("l");
            {3'd4, 7'd6}:  d = mcd_hit("p");
            {3'd4, 7'd7}:  d = mcd_hit("j");
            {3'd4, 7'd8}:  d = mcd_hit("b");
            {3'd4, 7'd9}:  d = mcd_hit("x");
            {3'd4, 7'd10}: d = mcd_hit("c");
            {3'd4, 7'd11}: d = mcd_hit("y");
            {3'd4, 7'd12}: d = mcd_hit("z");
            {3'd4, 7'd13}: d = mcd_hit("q");
            {3'd5, 7'd0}:  d = mcd_hit("5");
            {3'd5, 7'd1}:  d = mcd_hit("4");
            {3'd5, 7'd3}:  d = mcd_hit("3");
            {3'd5, 7'd7}:  d = mcd_hit("2");
            {3'd5, 7'd8}:  d = mcd_hit("&");
            {3'd5, 7'd10}: d = mcd_hit("+");
            {3'd5, 7'd15}: d = mcd_hit("1");
            {3'd5, 7'd16}: d = mcd_hit("6");
            {3'd5, 7'd17}: d = mcd_hit("=");
            {3'd5, 7'd18}: d = mcd_hit("/");
            {3'd5, 7'd22}: d = mcd_hit("(");
            {3'd5, 7'd24}: d = mcd_hit("7");
            {3'd5, 7'd28}: d = mcd_hit("8");
            {3'd5, 7'd30}: d = mcd_hit("9");
            {3'd5, 7'd31}: d = mcd_hit("0");
            {3'd6, 7'd12}: d = mcd_hit("?");
            {3'd6, 7'd13}: d = mcd_hit("_");
            {3'd6, 7'd18}: d = mcd_hit("\"");
            {3'd6, 7'd21}: d = mcd_hit(".");
            {3'd6, 7'd26}: d = mcd_hit("@");
            {3'd6, 7'd30}: d = mcd_hit("'");
            {3'd6, 7'd33}: d = mcd_hit("-");
            {3'd6, 7'd42}: d = mcd_hit(";");
            {3'd6, 7'd43}: d = mcd_hit("!");
            {3'd6, 7'd45}: d = mcd_hit(")");
            {3'd6, 7'd51}: d = mcd_hit(",");
            {3'd6, 7'd56}: d = mcd_hit(":");
            {3'd7, 7'd9}:  d = mcd_hit("$");
            default:       d = '0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/mcd_front.sv -----
// ----------------------------------------------------------------------------
// mcd_front
// Collects dash and dot bytes into a symbol group and emits closed groups.
// ----------------------------------------------------------------------------
module mcd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_line,
    output logic            o_grp_push,
    output mcd_pkg::t_group o_grp
);
    import mcd_pkg::*;

    logic [MCD_SYM_W-1:0] r_bits, n_bits;
    logic [MCD_CNT_W-1:0] r_count, n_count;
    logic                 w_is_dash;
    logic                 w_is_sym;
    logic [MCD_SYM_W-1:0] w_shift_bits;
    logic [MCD_CNT_W-1:0] w_shift_cnt;

    assign w_is_dash    = (i_in_byte == MCD_DASH);
    assign w_is_sym     = w_is_dash || (i_in_byte == MCD_DOT);
    assign w_shift_bits = {r_bits[MCD_SYM_W-2:0], w_is_dash};
    assign w_shift_cnt  = r_count + MCD_CNT_W'(1);

    always_comb begin
        o_grp_push = 1'b0;
        o_grp      = '{count: r_count, bits: r_bits};
        n_bits     = r_bits;
        n_count    = r_count;
        if (i_acc) begin
            if (w_is_sym) begin
                if (w_shift_cnt == MCD_MAX_SYMBOLS) begin
                    // full group closes at once; a flag on this byte finds it empty
                    o_grp_push = 1'b1;
                    o_grp      = '{count: w_shift_cnt, bits: w_shift_bits};
                    n_bits     = '0;
                    n_count    = '0;
                end else if (i_end_of_line) begin
                    o_grp_push = 1'b1;
                    o_grp      = '{count: w_shift_cnt, bits: w_shift_bits};
                    n_bits     = '0;
                    n_count    = '0;
                end else begin
                    n_bits  = w_shift_bits;
                    n_count = w_shift_cnt;
                end
            end else if (r_count != '0) begin
                o_grp_push = 1'b1;
                n_bits     = '0;
                n_count    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/mcd_queue.sv -----
// ----------------------------------------------------------------------------
// mcd_queue
// Short register queue carrying closed groups from front to back.
// ----------------------------------------------------------------------------
module mcd_queue #(
    parameter int DATA_W = mcd_pkg::MCD_GROUP_W,
    parameter int DEPTH  = mcd_pkg::MCD_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rd,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_full,
    output logic              o_empty
);
    import mcd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mcd_back.sv -----
// ----------------------------------------------------------------------------
// mcd_back
// Looks up closed groups and holds the decoded character for the consumer.
// ----------------------------------------------------------------------------
module mcd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_grp_valid,
    input  mcd_pkg::t_group                 i_grp,
    output logic                            o_grp_take,
    input  logic                            i_pop,
    output logic                            o_empty,
    output logic [mcd_pkg::MCD_CHAR_W-1:0]  o_character
);
    import mcd_pkg::*;

    logic                  r_valid, n_valid;
    logic [MCD_CHAR_W-1:0] r_char;
    t_decode               w_dec;

    assign w_dec       = mcd_decode(i_grp);
    // take a group whenever the output slot is free or being drained
    assign o_grp_take  = i_grp_valid && (!r_valid || i_pop);
    assign o_empty     = !r_valid;
    assign o_character = r_char;

    always_comb begin
        n_valid = r_valid;
        if (o_grp_take) begin
            n_valid = w_dec.hit;     // drop unknown groups
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_take && w_dec.hit) begin
            r_char <= w_dec.character;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- rtl/morse_code_decoder.sv -----
// ----------------------------------------------------------------------------
// morse_code_decoder
// Morse decoder: byte collector, group queue and table lookup stage.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the collector takes a byte every cycle
//   while the group queue has room.
// Path: the group of a closing byte is written into the queue, then looked up
//   into the output register once the output slot is free or being popped.
// Reset: synchronous, active low; clears the open group, the queue and the
//   output slot. No clearing pass.
module morse_code_decoder #(
    parameter int QUEUE_DEPTH = mcd_pkg::MCD_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_end_of_line,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [mcd_pkg::MCD_CHAR_W-1:0] o_character
);
    import mcd_pkg::*;

    logic                   w_in_acc;
    logic                   w_grp_push;
    t_group                 w_grp;
    logic [MCD_GROUP_W-1:0] w_q_rdata;
    t_group                 w_q_head;
    logic                   w_q_empty;
    logic                   w_grp_take;

    assign w_in_acc = i_push && !o_full;
    assign w_q_head = t_group'(w_q_rdata);

    mcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_in_acc),
        .i_in_byte     (i_in_byte),
        .i_end_of_line (i_end_of_line),
        .o_grp_push    (w_grp_push),
        .o_grp         (w_grp)
    );

    mcd_queue #(
        .DATA_W (MCD_GROUP_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_grp_push),
        .i_wdata (w_grp),
        .i_rd    (w_grp_take),
        .o_rdata (w_q_rdata),
        .o_full  (o_full),
        .o_empty (w_q_empty)
    );

    mcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (!w_q_empty),
        .i_grp       (w_q_head),
        .o_grp_take  (w_grp_take),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_character (o_character)
    );

    a_grp_only_on_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_push |-> w_in_acc)
        else $error("group closed without an accepted request");

    a_grp_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_push |-> (w_grp.count != '0))
        else $error("empty group pushed to queue");

    a_out_from_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && w_q_empty) |=> o_empty)
        else $error("result appeared without a queued group");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not cleared by reset");

endmodule
